// ===== rtl/kps_pkg.sv =====
// Shared types and constants for the key/payload insertion sorter.
package kps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Region of the ring a cell belongs to: empty, pending (ascending from cell 0)
  // or already read (descending from the last cell).
  typedef enum logic [1:0] {
    TAG_EMPTY,
    TAG_BACK,
    TAG_FRONT
  } tag_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_LOAD_BACK,
    OP_LOAD_FRONT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    tag_t               tag;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  x;
    logic [DATA_W-1:0]  y;
    logic [DATA_W-1:0]  z;
    logic [IDX_W-1:0]   idx;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t fresh;
  } cell_ctrl_t;

  typedef struct packed {
    entry_t ent;
    logic   gt;
  } cell_link_t;

endpackage

// ===== rtl/kps_cell.sv =====
// One sorter cell: holds an entry and moves it to or from a ring neighbor.
module kps_cell import kps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       is_first,
  input  logic       is_last,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t self
);

  entry_t ent;
  entry_t ent_next;
  logic   gt;
  logic   gap;
  logic   back_side;
  logic   left_back_disp;
  logic   left_front_disp;

  assign gt        = ent.key > ctrl.fresh.key;
  assign self.ent  = ent;
  assign self.gt   = gt;

  // first empty cell after the pending region
  assign gap       = (ent.tag == TAG_EMPTY) && (is_first || (left.ent.tag == TAG_BACK));
  assign back_side = (ent.tag == TAG_BACK) || gap;

  assign left_back_disp  = !is_first && (left.ent.tag == TAG_BACK) && left.gt;
  assign left_front_disp = !is_first && (left.ent.tag == TAG_FRONT) && left.gt;

  always_comb begin
    ent_next = ent;
    case (ctrl.op)
      OP_ROTATE: begin
        ent_next = right.ent;
        if (is_last) begin
          ent_next.tag = TAG_FRONT;
        end
      end
      OP_LOAD_BACK: begin
        if (((ent.tag == TAG_BACK) && gt) || gap) begin
          if (left_back_disp) begin
            ent_next = left.ent;
          end else begin
            ent_next     = ctrl.fresh;
            ent_next.tag = TAG_BACK;
          end
        end
      end
      OP_LOAD_FRONT: begin
        if ((ent.tag == TAG_FRONT) && gt) begin
          if (left_front_disp) begin
            ent_next = left.ent;
          end else begin
            ent_next     = ctrl.fresh;
            ent_next.tag = TAG_FRONT;
          end
        end else if (back_side) begin
          ent_next     = left.ent;
          ent_next.tag = TAG_BACK;
        end
      end
      OP_CLEAR: begin
        ent_next.tag = TAG_EMPTY;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.tag <= TAG_EMPTY;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

// ===== rtl/key_payload_sorter.sv =====
// Stable key/payload insertion sorter built as a ring of cells.
// Throughput: one word per cycle on the input for every command; the ring of
// MAX_POINTS cells updates at once for a load, read or clear.
// A read result appears on the output register in the cycle after accept.
// The input stalls only while a read result waits on the output.
// Reset (synchronous, active high) empties all cells and clears counts and flag.
module key_payload_sorter import kps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [DATA_W-1:0] sort_key,
  input  logic [DATA_W-1:0] x_coord,
  input  logic [DATA_W-1:0] y_coord,
  input  logic [DATA_W-1:0] z_coord,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_key,
  output logic [DATA_W-1:0] out_x,
  output logic [DATA_W-1:0] out_y,
  output logic [DATA_W-1:0] out_z,
  output logic [IDX_W-1:0]  arrival_index,
  output logic              is_empty,
  output logic              dropped_any
);

  cell_link_t links [MAX_POINTS];
  cell_ctrl_t ctrl;

  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] arrivals;
  logic             drop_flag;

  logic accept;
  logic do_load;
  logic do_read;
  logic do_clear;
  logic full;
  logic head_pending;
  logic front_hit;
  logic out_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign do_load  = accept && (command == CMD_LOAD);
  assign do_read  = accept && (command == CMD_READ);
  assign do_clear = accept && (command == CMD_CLEAR);

  assign full         = entry_count == CNT_W'(MAX_POINTS);
  assign head_pending = links[0].ent.tag == TAG_BACK;
  assign front_hit    = (links[MAX_POINTS-1].ent.tag == TAG_FRONT) && links[MAX_POINTS-1].gt;

  always_comb begin
    ctrl.fresh.tag = TAG_BACK;
    ctrl.fresh.key = sort_key;
    ctrl.fresh.x   = x_coord;
    ctrl.fresh.y   = y_coord;
    ctrl.fresh.z   = z_coord;
    ctrl.fresh.idx = arrivals;
    ctrl.op        = OP_HOLD;
    if (do_clear) begin
      ctrl.op = OP_CLEAR;
    end else if (do_load && !full) begin
      ctrl.op = front_hit ? OP_LOAD_FRONT : OP_LOAD_BACK;
    end else if (do_read && head_pending) begin
      ctrl.op = OP_ROTATE;
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int LEFT_I  = (i == 0) ? MAX_POINTS - 1 : i - 1;
    localparam int RIGHT_I = (i == MAX_POINTS - 1) ? 0 : i + 1;
    kps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .is_first (i == 0),
      .is_last  (i == MAX_POINTS - 1),
      .left     (links[LEFT_I]),
      .right    (links[RIGHT_I]),
      .self     (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      arrivals    <= '0;
      drop_flag   <= 1'b0;
    end else if (do_clear) begin
      entry_count <= '0;
      arrivals    <= '0;
      drop_flag   <= 1'b0;
    end else if (do_load) begin
      if (full) begin
        drop_flag <= 1'b1;
      end else begin
        entry_count <= entry_count + CNT_W'(1);
        arrivals    <= arrivals + IDX_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (do_read) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      dropped_any <= drop_flag;
      is_empty    <= !head_pending;
      if (head_pending) begin
        out_key       <= links[0].ent.key;
        out_x         <= links[0].ent.x;
        out_y         <= links[0].ent.y;
        out_z         <= links[0].ent.z;
        arrival_index <= links[0].ent.idx;
      end else begin
        out_key       <= '0;
        out_x         <= '0;
        out_y         <= '0;
        out_z         <= '0;
        arrival_index <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_POINTS))
    else $error("entry count above capacity");

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> ((links[0].ent.tag == TAG_EMPTY) &&
                            (links[MAX_POINTS-1].ent.tag == TAG_EMPTY)))
    else $error("cells occupied while count is zero");

  a_drop_sets: assert property (@(posedge clk) disable iff (rst)
    (do_load && full) |=> drop_flag)
    else $error("load into full store did not set drop flag");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    do_read |=> out_valid)
    else $error("read accepted without a result word");

endmodule
